// ===== hw/rtl/bgr_pkg.sv =====
// shared types and constants for the block group reverser
// no dependencies; used by bgr_cell and block_group_reverser
`default_nettype none

package bgr_pkg;

	// largest group that the cell chain can hold
	localparam int MaxGroup = 16;
	// bits of an index into the chain, and of a count up to MaxGroup
	localparam int IdxW = (MaxGroup > 1) ? $clog2(MaxGroup) : 1;
	localparam int CntW = $clog2(MaxGroup + 1);

	typedef logic signed [31:0] value_t;

	typedef struct packed {
		value_t value;
		logic   list_end;
	} item_t;

	typedef struct packed {
		value_t out_value;
		logic   run_last;
		logic   out_list_end;
	} result_t;

	// per-cycle move of the whole chain
	typedef struct packed {
		logic shift_up;
		logic shift_down;
	} cell_ctrl_t;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bgr_cell.sv =====
// one storage cell of the reversing chain
// depends on bgr_pkg for the value and control types
`default_nettype none

module bgr_cell (
	input  wire                 clk,
	input  bgr_pkg::cell_ctrl_t ctrl,
	input  bgr_pkg::value_t     up_in,
	input  bgr_pkg::value_t     dn_in,
	output bgr_pkg::value_t     value
);
	import bgr_pkg::*;

	value_t val_q;

	// up takes the lower neighbor, down takes the upper neighbor
	always_ff @(posedge clk) begin
		if (ctrl.shift_up) begin
			val_q <= up_in;
		end else if (ctrl.shift_down) begin
			val_q <= dn_in;
		end
	end

	assign value = val_q;

endmodule

`default_nettype wire

// ===== hw/rtl/block_group_reverser.sv =====
// block group reverser: reverses a value stream in groups of group_size
// the first result of a group is presented in the cycle after the request that completes it
// throughput: one request per cycle while a group fills; a group's results leave one at a time,
//   set by the single read point of the cell chain, and no request is taken meanwhile
// reset: arst_n clears the fill count and control and sets group_size to 1; cells hold no reset
`default_nettype none

module block_group_reverser (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              cfg_we,
	input  wire [4:0]        cfg_wdata,
	input  wire              item_valid,
	output logic             item_ready,
	input  bgr_pkg::item_t   item,
	output logic             result_valid,
	input  wire              result_ready,
	output bgr_pkg::result_t result
);
	import bgr_pkg::*;

	// configuration
	logic [4:0] group_size_q;

	// control state
	state_t          state_q, state_d;
	logic [IdxW-1:0] fill_q;      // values buffered in the current group
	logic [IdxW-1:0] last_idx_q;  // chain position of the oldest value while emitting
	logic [CntW-1:0] rem_q;       // results still to deliver
	logic            rev_q;       // full group: newest first
	logic            end_q;       // the request that closed the group ended the list

	// chain
	cell_ctrl_t      ctrl;
	value_t          cell_val [MaxGroup];

	logic            item_acc;
	logic            result_acc;
	logic [CntW-1:0] k_eff;
	logic [CntW-1:0] n_new;
	logic            full_grp;
	logic            emit;
	logic [IdxW-1:0] rd_idx;

	assign item_acc   = item_valid && item_ready;
	assign result_acc = result_valid && result_ready;

	// effective group size: zero acts as one, clamp at the chain length
	always_comb begin
		if (group_size_q == 5'd0) begin
			k_eff = CntW'(1);
		end else if ({27'd0, group_size_q} > 32'(MaxGroup)) begin
			k_eff = CntW'(MaxGroup);
		end else begin
			k_eff = CntW'(group_size_q);
		end
	end

	// count including the value of this request
	assign n_new    = CntW'(fill_q) + CntW'(1);
	assign full_grp = n_new >= k_eff;
	assign emit     = full_grp || item.list_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_size_q <= 5'd1;
		end else if (cfg_we) begin
			group_size_q <= cfg_wdata;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_acc && emit) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (result_acc && rem_q == CntW'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		item_ready      = 1'b0;
		result_valid    = 1'b0;
		ctrl.shift_up   = 1'b0;
		ctrl.shift_down = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready    = 1'b1;
				ctrl.shift_up = item_valid;
			end
			ST_EMIT: begin
				result_valid    = 1'b1;
				// in-order drain pushes toward the oldest slot, reversed drain toward slot 0
				ctrl.shift_up   = result_ready && !rev_q;
				ctrl.shift_down = result_ready && rev_q;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			last_idx_q <= '0;
			rem_q      <= '0;
			rev_q      <= 1'b0;
			end_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (item_acc) begin
				if (emit) begin
					fill_q     <= '0;
					last_idx_q <= fill_q;
					rem_q      <= n_new;
					rev_q      <= full_grp;
					end_q      <= item.list_end;
				end else begin
					fill_q <= fill_q + IdxW'(1);
				end
			end else if (result_acc) begin
				rem_q <= rem_q - CntW'(1);
			end
		end
	end

	// row of cells; while a group fills, slot 0 holds the newest value
	for (genvar i = 0; i < MaxGroup; i++) begin : g_cell
		value_t up_in;
		value_t dn_in;

		if (i == 0) begin : g_first
			assign up_in = item.value;
		end else begin : g_mid_up
			assign up_in = cell_val[i-1];
		end

		if (i == MaxGroup - 1) begin : g_last
			assign dn_in = '0;
		end else begin : g_mid_dn
			assign dn_in = cell_val[i+1];
		end

		bgr_cell u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.up_in (up_in),
			.dn_in (dn_in),
			.value (cell_val[i])
		);
	end

	// read point: slot 0 when reversed, the oldest slot when in order
	assign rd_idx = rev_q ? '0 : last_idx_q;

	assign result.out_value    = cell_val[rd_idx];
	assign result.run_last     = rem_q == CntW'(1);
	assign result.out_list_end = (rem_q == CntW'(1)) && end_q;

	// a closed group must start delivering on the next cycle
	a_emit_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(item_acc && emit) |=> result_valid)
		else $error("group closed but no result presented");

	// while results are pending there is at least one left to send
	a_rem_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (rem_q != '0))
		else $error("result presented with empty count");

	// the last result of a group ends the drain
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(result_acc && result.run_last) |=> (!result_valid && item_ready))
		else $error("drain did not stop after last result");

	// no new request is taken while a group drains
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !item_ready)
		else $error("request taken during drain");

endmodule

`default_nettype wire

// ===== tb/tb_block_group_reverser.sv =====
// testbench for block_group_reverser: drives value lists through the valid/ready request
// channel, predicts the group-reversed stream and checks every result field by field
// depends on bgr_pkg and block_group_reverser
`default_nettype none

module tb_block_group_reverser;
	import bgr_pkg::*;

	// idle patterns, one per phase
	localparam int IDLE_NONE   = 0;
	localparam int IDLE_SEND   = 1;
	localparam int IDLE_RECV   = 2;
	localparam int IDLE_BOTH   = 3;
	// cycles to let the block settle before a register write or the end
	localparam int SETTLE_CYC  = 6;
	localparam int FINAL_CYC   = 24;
	// generous bound on the whole run, in time units
	localparam int RUN_LIMIT   = 400000;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic       item_valid = 1'b0;
	logic       item_ready;
	item_t      req_bus = '0;
	logic       result_valid;
	logic       result_ready = 1'b0;
	result_t    res_bus;

	// requests waiting to be driven, filled by the stimulus process
	item_t      pending_reqs[$];
	// reordered values the block still owes us
	result_t    owed_results[$];

	// predictor state: its own copy of the register, the buffer and the count
	logic [4:0]  model_group_size = 5'd1;
	value_t      held_vals[MaxGroup];
	int unsigned held_count = 0;

	int unsigned mismatches = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	block_group_reverser dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (req_bus),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (res_bus)
	);

	always #1 clk = ~clk;

	// group size as the block applies it: zero acts as one, above the chain saturates
	function automatic int unsigned eff_group(input logic [4:0] k);
		if (k == 0)
			return 1;
		if (k > MaxGroup)
			return MaxGroup;
		return k;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// buffers one accepted request and queues the values it releases, if any
	task automatic predict_reorder(input item_t req);
		int unsigned k;
		int unsigned n;
		result_t     r;
		k = eff_group(model_group_size);
		held_vals[held_count] = req.value;
		n = held_count + 1;
		if (n >= k || req.list_end) begin
			for (int unsigned i = 0; i < n; i++) begin
				// a full group comes out reversed, a short tail in arrival order
				r.out_value    = (n >= k) ? held_vals[n - 1 - i] : held_vals[i];
				r.run_last     = (i == n - 1);
				r.out_list_end = (i == n - 1) && req.list_end;
				owed_results = {owed_results, r};
			end
			held_count = 0;
		end else begin
			held_count = n;
		end
	endtask

	// request driver: holds the payload until accepted, then loads the next one
	always @(posedge clk) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else if (!item_valid || item_ready) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				item_valid <= 1'b1;
				req_bus    <= pending_reqs.pop_front();
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		if (!arst_n)
			result_ready <= 1'b0;
		else
			result_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// monitor: predicts on each accepted request, checks each accepted result
	always @(posedge clk) begin
		if (arst_n) begin
			// prediction first; a write at this edge only affects later requests
			if (item_valid && item_ready)
				predict_reorder(req_bus);
			if (cfg_we)
				model_group_size <= cfg_wdata;
			if (result_valid && result_ready) begin
				if (owed_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result value %0d",
						res_bus.out_value));
				end else begin
					if (res_bus.out_value !== owed_results[0].out_value)
						report_mismatch($sformatf("out_value %0d, wanted %0d",
							res_bus.out_value, owed_results[0].out_value));
					if (res_bus.run_last !== owed_results[0].run_last)
						report_mismatch($sformatf("run_last %b, wanted %b",
							res_bus.run_last, owed_results[0].run_last));
					if (res_bus.out_list_end !== owed_results[0].out_list_end)
						report_mismatch($sformatf("out_list_end %b, wanted %b",
							res_bus.out_list_end, owed_results[0].out_list_end));
					void'(owed_results.pop_front());
				end
			end
		end
	end

	// waits until every request is taken and every owed result has come back,
	// then lets the block settle; requests that release nothing may still be in flight
	// checks sit on the falling edge so the driver and monitor have settled
	task automatic drain_all();
		while (pending_reqs.size() != 0 || item_valid)
			@(negedge clk);
		while (owed_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_group_size(input logic [4:0] k);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= k;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_idle(input int mode);
		case (mode)
			IDLE_SEND: begin send_idle_pct = 48; recv_stall_pct = 0; end
			IDLE_RECV: begin send_idle_pct = 0; recv_stall_pct = 48; end
			IDLE_BOTH: begin send_idle_pct = 32; recv_stall_pct = 32; end
			default:   begin send_idle_pct = 0; recv_stall_pct = 0; end
		endcase
	endtask

	task automatic push_req(input value_t v, input logic last);
		item_t req;
		req.value    = v;
		req.list_end = last;
		pending_reqs = {pending_reqs, req};
	endtask

	// random element value, leaning on the extremes now and then
	function automatic value_t rand_value();
		case ($urandom_range(7))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0;
			3: return -32'sd1;
			default: return value_t'($urandom());
		endcase
	endfunction

	// well-formed lists of random length; a few lists are cut short by an early end
	task automatic queue_random_lists(input logic [4:0] k, input int unsigned budget);
		int unsigned len;
		int unsigned sent;
		int unsigned k_eff;
		sent  = 0;
		k_eff = eff_group(k);
		while (sent < budget) begin
			len = $urandom_range(2 * k_eff + 2, 1);
			// last list of the phase is trimmed to the budget
			if (len > budget - sent)
				len = budget - sent;
			for (int unsigned j = 0; j < len; j++)
				push_req(rand_value(), (j == len - 1) || ($urandom_range(15) == 0));
			sent += len;
		end
	endtask

	initial begin
		logic [4:0] phase_k[8];
		int         phase_idle[8];

		phase_k    = '{5'd16, 5'd2, 5'd31, 5'd7, 5'd1, 5'd4, 5'd17, 5'd5};
		phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
			IDLE_SEND, IDLE_BOTH, IDLE_RECV, IDLE_NONE};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through at the reset group size, extreme values
		push_req(32'sh7FFF_FFFF, 1'b0);
		push_req(32'sh8000_0000, 1'b1);
		drain_all();

		// group size zero acts as pass-through
		write_group_size(5'd0);
		push_req(32'sh0, 1'b0);
		push_req(-32'sd1, 1'b1);
		drain_all();

		// full group, short tail in order, then a full group ending the list
		write_group_size(5'd3);
		set_idle(IDLE_BOTH);
		for (int i = 1; i <= 8; i++)
			push_req(value_t'(i), (i == 5) || (i == 8));
		drain_all();

		// group size shrunk while three values sit in the buffer
		set_idle(IDLE_NONE);
		write_group_size(5'd5);
		for (int i = 11; i <= 13; i++)
			push_req(value_t'(i), 1'b0);
		drain_all();
		write_group_size(5'd2);
		push_req(32'sd14, 1'b0);
		drain_all();

		// random phases across sizes, saturating ones included
		for (int p = 0; p < 8; p++) begin
			write_group_size(phase_k[p]);
			set_idle(phase_idle[p]);
			queue_random_lists(phase_k[p], 14);
			drain_all();
		end

		repeat (FINAL_CYC) @(posedge clk);
		if (mismatches == 0 && owed_results.size() == 0)
			$display("block_group_reverser verification clean");
		else
			$display("block_group_reverser verification failed");
		$finish;
	end

	// hang guard
	initial begin
		#RUN_LIMIT;
		$display("block_group_reverser verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== block_group_reverser.f =====
hw/rtl/bgr_pkg.sv
hw/rtl/bgr_cell.sv
hw/rtl/block_group_reverser.sv
tb/tb_block_group_reverser.sv
